// ===== rtl/core/prrts_pkg.sv =====
// Shared types and constants for the thread scheduler.
package prrts_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ADD      = 3'd1,
    OP_PERIODIC = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_KILL     = 3'd4,
    OP_LAUNCH   = 3'd5,
    OP_YIELD    = 3'd6
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SLOT  = 3'd1;
  localparam logic [2:0] ST_NO_SUCH  = 3'd2;
  localparam logic [2:0] ST_NO_KILL  = 3'd3;
  localparam logic [2:0] ST_TBL_FULL = 3'd4;

  localparam logic [7:0] PRIO_NONE = 8'd255;
  localparam int         ID_SHIFT  = 16;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic tick_start; // advance time
    logic task_step;  // examine one task entry
    logic wake_step;  // one wake step along the ring
    logic pick_init;  // start a pick walk
    logic pick_step;  // one pick step
    logic launch_step;// one launch scan step
    logic do_add;
    logic do_periodic;
    logic do_sleep;
    logic do_kill;
    logic emit_task;  // present a task row
    logic emit_final; // present the closing row
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic task_done;   // task scan finished
    logic task_fire;   // entry under scan is due
    logic steps_done;  // ring or scan walk finished
    logic kill_current;// kill hit the current slot
    logic out_busy;    // output register still full
  } stat_t;

endpackage

// ===== rtl/core/prrts_ctrl.sv =====
// Sequencer for the thread scheduler operations.
module prrts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  prrts_pkg::stat_t  st,
  output logic              busy,
  output prrts_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_TASK, S_TASK_OUT, S_WAKE, S_PICK_INIT, S_PICK,
    S_LAUNCH, S_FINAL
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.op)
          prrts_pkg::OP_TICK: begin
            cmd.tick_start = 1'b1;
            state_next = S_TASK;
          end
          prrts_pkg::OP_ADD: begin
            cmd.do_add = 1'b1;
            state_next = S_FINAL;
          end
          prrts_pkg::OP_PERIODIC: begin
            cmd.do_periodic = 1'b1;
            state_next = S_FINAL;
          end
          prrts_pkg::OP_SLEEP: begin
            cmd.do_sleep = 1'b1;
            state_next = S_PICK_INIT;
          end
          prrts_pkg::OP_KILL: begin
            cmd.do_kill = 1'b1;
            state_next = st.kill_current ? S_PICK_INIT : S_FINAL;
          end
          prrts_pkg::OP_LAUNCH: begin
            cmd.pick_init = 1'b1;
            state_next = S_LAUNCH;
          end
          prrts_pkg::OP_YIELD: state_next = S_PICK_INIT;
          default: state_next = S_FINAL;
        endcase
      end
      S_TASK: begin
        if (st.task_done) begin
          cmd.pick_init = 1'b1;
          state_next = S_WAKE;
        end else if (st.task_fire) begin
          state_next = S_TASK_OUT;
        end else begin
          cmd.task_step = 1'b1;
        end
      end
      S_TASK_OUT: begin
        // hold until the output register is free
        if (!st.out_busy) begin
          cmd.emit_task = 1'b1;
          cmd.task_step = 1'b1;
          state_next = S_TASK;
        end
      end
      S_WAKE: begin
        cmd.wake_step = 1'b1;
        if (st.steps_done) state_next = S_PICK_INIT;
      end
      S_PICK_INIT: begin
        cmd.pick_init = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        if (st.steps_done) state_next = S_FINAL;
        else cmd.pick_step = 1'b1;
      end
      S_LAUNCH: begin
        if (st.steps_done) state_next = S_FINAL;
        else cmd.launch_step = 1'b1;
      end
      S_FINAL: begin
        if (!st.out_busy) begin
          cmd.emit_final = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== rtl/core/prrts_dp.sv =====
// Thread ring, task table and output register of the scheduler.
module prrts_dp #(
  parameter int THREAD_SLOTS = 8,
  parameter int TASK_SLOTS   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  prrts_pkg::cmd_t   cmd,
  output prrts_pkg::stat_t  st,
  input  logic [2:0]        in_opcode,
  input  logic [7:0]        in_prio,
  input  logic [31:0]       in_amount,
  input  logic [31:0]       in_target_id,
  input  logic [7:0]        in_blocked_mask,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [2:0]        out_fired_task,
  output logic [2:0]        out_running_slot,
  output logic [31:0]       out_running_id,
  output logic [31:0]       out_new_id,
  output logic [2:0]        out_status,
  output logic              out_last
);

  localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int TW = $clog2(TASK_SLOTS + 1);
  localparam int CW = $clog2(THREAD_SLOTS + 1);
  localparam int KW = $clog2(THREAD_SLOTS + 1);
  localparam int TIW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic [31:0]   tick_time;
  logic [SW-1:0] ring_next [THREAD_SLOTS];
  logic [SW-1:0] ring_prev [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] slot_alive, slot_asleep;
  logic [31:0]   wake_time [THREAD_SLOTS];
  logic [7:0]    slot_priority [THREAD_SLOTS];
  logic [31:0]   slot_ident [THREAD_SLOTS];
  logic [15:0]   id_counter;
  logic [CW-1:0] thread_count;
  logic [SW-1:0] current_slot;
  logic [TW-1:0] task_count;
  logic [31:0]   task_period [TASK_SLOTS];
  logic [31:0]   task_due [TASK_SLOTS];

  prrts_pkg::op_t op;
  logic [31:0]   amount, target;
  logic [7:0]    prio, mask;
  logic [2:0]    status;
  logic [31:0]   new_id;

  logic [TW-1:0] task_idx;
  logic [SW-1:0] walk_p;
  logic [KW-1:0] walk_cnt;
  logic [7:0]    best;

  logic [THREAD_SLOTS-1:0] blocked;
  always_comb begin
    for (int s = 0; s < THREAD_SLOTS; s++)
      blocked[s] = (s < 8) ? mask[s % 8] : 1'b0;
  end

  // lowest free slot and lowest alive slot with matching identifier
  logic [SW-1:0] free_slot, kill_slot;
  logic          free_found, kill_found;
  always_comb begin
    free_slot = '0; free_found = 1'b0;
    kill_slot = '0; kill_found = 1'b0;
    for (int s = THREAD_SLOTS - 1; s >= 0; s--) begin
      if (!slot_alive[s]) begin
        free_slot = SW'(s); free_found = 1'b1;
      end
      if (slot_alive[s] && slot_ident[s] == target) begin
        kill_slot = SW'(s); kill_found = 1'b1;
      end
    end
  end

  logic [TIW-1:0] tsel;
  assign tsel = task_idx[TIW-1:0];
  logic task_done, task_fire;
  assign task_done = (task_idx >= task_count);
  assign task_fire = !task_done && (tick_time >= task_due[tsel]);

  logic walk_limit;
  assign walk_limit = (op == prrts_pkg::OP_TICK && cmd.wake_step) ?
                      (walk_cnt == KW'(THREAD_SLOTS - 1)) : 1'b0;

  assign st.op           = op;
  assign st.task_done    = task_done;
  assign st.task_fire    = task_fire;
  assign st.steps_done   = (op == prrts_pkg::OP_LAUNCH) ?
                           (walk_cnt == KW'(THREAD_SLOTS)) :
                           (op == prrts_pkg::OP_TICK && cmd.wake_step) ? walk_limit :
                           (walk_cnt >= KW'(thread_count));
  assign st.kill_current = (thread_count != '0) && kill_found &&
                           (kill_slot == current_slot);
  assign st.out_busy     = out_valid && !out_ready;

  logic [SW-1:0] lsel;
  assign lsel = walk_cnt[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_time    <= '0;
      slot_alive   <= '0;
      slot_asleep  <= '0;
      id_counter   <= '0;
      thread_count <= '0;
      current_slot <= '0;
      task_count   <= '0;
      out_valid    <= 1'b0;
      for (int s = 0; s < THREAD_SLOTS; s++) begin
        ring_next[s] <= '0;
        ring_prev[s] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        op       <= prrts_pkg::op_t'(in_opcode);
        prio     <= in_prio;
        amount   <= in_amount;
        target   <= in_target_id;
        mask     <= in_blocked_mask;
        status   <= prrts_pkg::ST_OK;
        new_id   <= '0;
        task_idx <= '0;
      end
      if (cmd.tick_start) tick_time <= tick_time + 32'd1;
      if (cmd.task_step) begin
        if (task_fire) task_due[tsel] <= tick_time + task_period[tsel];
        task_idx <= task_idx + TW'(1);
      end
      if (cmd.pick_init) begin
        walk_p   <= ring_next[current_slot];
        walk_cnt <= '0;
        best     <= prrts_pkg::PRIO_NONE;
      end
      if (cmd.wake_step) begin
        if (slot_asleep[walk_p] && wake_time[walk_p] <= tick_time)
          slot_asleep[walk_p] <= 1'b0;
        walk_p   <= ring_next[walk_p];
        walk_cnt <= walk_cnt + KW'(1);
      end
      if (cmd.pick_step) begin
        if (slot_alive[walk_p] && !slot_asleep[walk_p] && !blocked[walk_p] &&
            slot_priority[walk_p] < best) begin
          current_slot <= walk_p;
          best <= slot_priority[walk_p];
        end
        walk_p   <= ring_next[walk_p];
        walk_cnt <= walk_cnt + KW'(1);
      end
      if (cmd.launch_step) begin
        if (slot_alive[lsel] && slot_priority[lsel] < best) begin
          current_slot <= lsel;
          best <= slot_priority[lsel];
        end
        walk_cnt <= walk_cnt + KW'(1);
      end
      if (cmd.do_add) begin
        if (!free_found) begin
          status <= prrts_pkg::ST_NO_SLOT;
        end else begin
          if (thread_count == '0) begin
            ring_next[free_slot] <= free_slot;
            ring_prev[free_slot] <= free_slot;
          end else begin
            ring_prev[free_slot] <= current_slot;
            ring_next[free_slot] <= ring_next[current_slot];
            ring_prev[ring_next[current_slot]] <= free_slot;
            ring_next[current_slot] <= free_slot;
          end
          slot_asleep[free_slot]   <= 1'b0;
          slot_priority[free_slot] <= prio;
          slot_ident[free_slot]    <= {id_counter, 16'(free_slot)};
          new_id                   <= {id_counter, 16'(free_slot)};
          id_counter               <= id_counter + 16'd1;
          slot_alive[free_slot]    <= 1'b1;
          thread_count             <= thread_count + CW'(1);
        end
      end
      if (cmd.do_periodic) begin
        if (task_count >= TW'(TASK_SLOTS)) begin
          status <= prrts_pkg::ST_TBL_FULL;
        end else begin
          task_period[task_count[TIW-1:0]] <= amount;
          task_due[task_count[TIW-1:0]] <= (task_count == '0) ? tick_time + amount :
              tick_time + amount + 32'd1 + 32'(task_count);
          task_count <= task_count + TW'(1);
        end
      end
      if (cmd.do_sleep) begin
        wake_time[current_slot]   <= tick_time + amount;
        slot_asleep[current_slot] <= 1'b1;
      end
      if (cmd.do_kill) begin
        if (thread_count == '0) begin
          status <= prrts_pkg::ST_NO_KILL;
        end else if (!kill_found) begin
          status <= prrts_pkg::ST_NO_SUCH;
        end else begin
          slot_alive[kill_slot] <= 1'b0;
          ring_prev[ring_next[kill_slot]] <= ring_prev[kill_slot];
          ring_next[ring_prev[kill_slot]] <= ring_next[kill_slot];
          thread_count <= thread_count - CW'(1);
        end
      end
      if (cmd.emit_task) begin
        out_valid        <= 1'b1;
        out_kind         <= 1'b0;
        out_fired_task   <= 3'(task_idx);
        out_running_slot <= '0;
        out_running_id   <= '0;
        out_new_id       <= '0;
        out_status       <= prrts_pkg::ST_OK;
        out_last         <= 1'b0;
      end
      if (cmd.emit_final) begin
        out_valid        <= 1'b1;
        out_kind         <= 1'b1;
        out_fired_task   <= '0;
        out_running_slot <= 3'(current_slot);
        out_running_id   <= slot_alive[current_slot] ? slot_ident[current_slot] : '0;
        out_new_id       <= new_id;
        out_status       <= status;
        out_last         <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/priority_round_robin_thread_scheduler_top.sv =====
// Top level of the priority round-robin thread scheduler.
// One item at a time. A tick scans the task table, emitting a row per due task,
// wakes sleeping threads along the ring, then picks among the live threads; sleep,
// yield and a kill of the running thread pick among the live threads; launch scans every slot.
// The next item is taken in the cycle after the closing item is loaded; output stalls delay that item.
// Synchronous reset clears time, ring, flags and counters; no clearing pass.
module priority_round_robin_thread_scheduler_top #(
  parameter int THREAD_SLOTS = 8,
  parameter int TASK_SLOTS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // opcode[2:0] prio[10:3] amount[42:11] target_id[74:43]
                                // blocked_mask[82:75], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // fired_task[2:0] running_slot[5:3] running_id[37:6]
                                // new_id[69:38] status[72:70], zero pad
  output logic        m_tuser,  // kind
  output logic        m_tlast   // last
);

  prrts_pkg::cmd_t  cmd;
  prrts_pkg::stat_t st;
  logic busy, in_fire;
  logic [2:0] fired_task, running_slot, status;
  logic [31:0] running_id, new_id;

  assign s_tready = !busy && !rst;
  assign in_fire  = s_tvalid && s_tready;

  prrts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .st(st), .busy(busy), .cmd(cmd)
  );

  prrts_dp #(.THREAD_SLOTS(THREAD_SLOTS), .TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .in_opcode(s_tdata[2:0]), .in_prio(s_tdata[10:3]),
    .in_amount(s_tdata[42:11]), .in_target_id(s_tdata[74:43]),
    .in_blocked_mask(s_tdata[82:75]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_kind(m_tuser),
    .out_fired_task(fired_task), .out_running_slot(running_slot),
    .out_running_id(running_id), .out_new_id(new_id), .out_status(status),
    .out_last(m_tlast)
  );

  assign m_tdata = {7'd0, status, new_id, running_id, running_slot, fired_task};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("item taken while busy");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser)) else $error("last and kind disagree");
  a_task_row: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[72:3] == '0)) else $error("bad task row");

endmodule

// ===== verif/tb_priority_round_robin_thread_scheduler_top.sv =====
// Self-checking testbench for the priority round-robin thread scheduler.
module tb_priority_round_robin_thread_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;
  localparam int NTASK = 8;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic       kind;
    logic [2:0] fired_task;
    logic [2:0] running_slot;
    logic [31:0] running_id;
    logic [31:0] new_id;
    logic [2:0] status;
    logic       last;
  } sched_row_t;

  class sched_scoreboard;
    logic [31:0] now;
    logic [2:0]  nxt[NSLOT];
    logic [2:0]  prv[NSLOT];
    logic        alive[NSLOT];
    logic        asleep[NSLOT];
    logic [31:0] wake_at[NSLOT];
    logic [7:0]  prio_of[NSLOT];
    logic [31:0] ident[NSLOT];
    logic [15:0] id_ctr;
    int          nthreads;
    logic [2:0]  cur;
    int          ntasks;
    logic [31:0] period[NTASK];
    logic [31:0] due[NTASK];
    sched_row_t  pending[$];
    int          errors;

    function new();
      now = 0; id_ctr = 0; nthreads = 0; cur = 0; ntasks = 0; errors = 0;
      for (int i = 0; i < NSLOT; i++) begin
        nxt[i] = 0; prv[i] = 0; alive[i] = 0; asleep[i] = 0;
        wake_at[i] = 0; prio_of[i] = 0; ident[i] = 0;
      end
    endfunction

    function void choose_next(logic [7:0] mask);
      int best;
      logic [2:0] p;
      best = prrts_pkg::PRIO_NONE;
      p = nxt[cur];
      for (int i = 0; i < nthreads; i++) begin
        if (alive[p] && !asleep[p] && !mask[p] && prio_of[p] < best) begin
          cur = p;
          best = prio_of[p];
        end
        p = nxt[p];
      end
    endfunction

    function void push_row(logic kind, logic [2:0] tsk, logic [2:0] st, logic [31:0] nid);
      sched_row_t r;
      r.kind = kind;
      r.fired_task = tsk;
      r.running_slot = kind ? cur : 3'd0;
      r.running_id = (kind && alive[cur]) ? ident[cur] : 32'd0;
      r.new_id = nid;
      r.status = st;
      r.last = kind;
      pending.push_back(r);
    endfunction

    function void note_item(logic [2:0] op, logic [7:0] pr, logic [31:0] amt,
                            logic [31:0] tgt, logic [7:0] mask);
      logic [2:0] st;
      logic [31:0] nid;
      int s, best;
      logic [2:0] p;
      st = prrts_pkg::ST_OK; nid = 0;
      case (op)
        prrts_pkg::OP_TICK: begin
          now = now + 32'd1;
          for (int i = 0; i < ntasks; i++)
            if (now >= due[i]) begin
              due[i] = now + period[i];
              push_row(1'b0, i[2:0], prrts_pkg::ST_OK, 32'd0);
            end
          p = nxt[cur];
          for (int i = 0; i < NSLOT; i++) begin
            if (asleep[p] && wake_at[p] <= now) asleep[p] = 0;
            p = nxt[p];
          end
          choose_next(mask);
        end
        prrts_pkg::OP_ADD: begin
          s = NSLOT;
          for (int i = NSLOT - 1; i >= 0; i--) if (!alive[i]) s = i;
          if (s == NSLOT) st = prrts_pkg::ST_NO_SLOT;
          else begin
            if (nthreads == 0) begin
              nxt[s] = 3'(s); prv[s] = 3'(s);
            end else begin
              prv[s] = cur;
              nxt[s] = nxt[cur];
              prv[nxt[s]] = 3'(s);
              nxt[cur] = 3'(s);
            end
            asleep[s] = 0;
            prio_of[s] = pr;
            ident[s] = {id_ctr, 16'(s)};
            id_ctr = id_ctr + 16'd1;
            alive[s] = 1;
            nthreads++;
            nid = ident[s];
          end
        end
        prrts_pkg::OP_PERIODIC: begin
          if (ntasks >= NTASK) st = prrts_pkg::ST_TBL_FULL;
          else begin
            period[ntasks] = amt;
            due[ntasks] = (ntasks == 0) ? now + amt : now + amt + 32'd1 + 32'(ntasks);
            ntasks++;
          end
        end
        prrts_pkg::OP_SLEEP: begin
          wake_at[cur] = now + amt;
          asleep[cur] = 1;
          choose_next(mask);
        end
        prrts_pkg::OP_KILL: begin
          if (nthreads == 0) st = prrts_pkg::ST_NO_KILL;
          else begin
            s = NSLOT;
            for (int i = NSLOT - 1; i >= 0; i--) if (alive[i] && ident[i] == tgt) s = i;
            if (s == NSLOT) st = prrts_pkg::ST_NO_SUCH;
            else begin
              alive[s] = 0;
              prv[nxt[s]] = prv[s];
              nxt[prv[s]] = nxt[s];
              nthreads--;
              if (s == cur) choose_next(mask);
            end
          end
        end
        prrts_pkg::OP_LAUNCH: begin
          best = prrts_pkg::PRIO_NONE;
          for (int i = 0; i < NSLOT; i++)
            if (alive[i] && prio_of[i] < best) begin
              cur = 3'(i); best = prio_of[i];
            end
        end
        prrts_pkg::OP_YIELD: choose_next(mask);
        default: ;
      endcase
      push_row(1'b1, 3'd0, st, nid);
    endfunction

    function void check_row(sched_row_t got);
      sched_row_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result item %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d got %0d", exp.kind, got.kind); errors++;
      end
      if (got.fired_task !== exp.fired_task) begin
        $error("fired_task: expected %0d got %0d", exp.fired_task, got.fired_task); errors++;
      end
      if (got.running_slot !== exp.running_slot) begin
        $error("running_slot: expected %0d got %0d", exp.running_slot, got.running_slot);
        errors++;
      end
      if (got.running_id !== exp.running_id) begin
        $error("running_id: expected %h got %h", exp.running_id, got.running_id); errors++;
      end
      if (got.new_id !== exp.new_id) begin
        $error("new_id: expected %h got %h", exp.new_id, got.new_id); errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d got %0d", exp.status, got.status); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  sched_scoreboard sb;
  logic [31:0] live_ids[$];
  int idle_cycles = 0;
  bit rx_stall_off = 0;

  always #6 clk = ~clk;

  priority_round_robin_thread_scheduler_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: check on accept, random stall between items
  initial begin
    int gap;
    sched_row_t r;
    sb = new();
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_stall_off ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      r.kind = m_tuser;
      r.fired_task = m_tdata[2:0];
      r.running_slot = m_tdata[5:3];
      r.running_id = m_tdata[37:6];
      r.new_id = m_tdata[69:38];
      r.status = m_tdata[72:70];
      r.last = m_tlast;
      sb.check_row(r);
      @(negedge clk);
    end
  end

  task automatic send_item(logic [2:0] op, logic [7:0] pr, logic [31:0] amt,
                           logic [31:0] tgt, logic [7:0] mask, bit burst = 0);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {5'd0, mask, tgt, amt, pr, op};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(op, pr, amt, tgt, mask);
    if (op == prrts_pkg::OP_ADD && sb.pending[$].status == prrts_pkg::ST_OK)
      live_ids.push_back(sb.pending[$].new_id);
    @(negedge clk);
  endtask

  task automatic drain_all();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_target();
    if (live_ids.size() == 0 || $urandom_range(0, 3) == 0) return $urandom;
    return live_ids[$urandom_range(0, live_ids.size() - 1)];
  endfunction

  initial begin
    int op;
    logic [31:0] t;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: empty scheduler corner cases, then fill and overflow
    send_item(prrts_pkg::OP_KILL, 8'd0, 0, 32'd0, 8'h00);
    send_item(prrts_pkg::OP_SLEEP, 8'd0, 32'd1, 0, 8'h00);
    send_item(prrts_pkg::OP_YIELD, 8'd0, 0, 0, 8'hff);
    send_item(3'd7, 8'hff, 32'hffffffff, 32'hffffffff, 8'hff);
    send_item(prrts_pkg::OP_ADD, 8'd255, 0, 0, 0);
    send_item(prrts_pkg::OP_ADD, 8'd0, 0, 0, 0);
    for (int i = 0; i < 7; i++)
      send_item(prrts_pkg::OP_ADD, 8'($urandom_range(0, 5)), 0, 0, 0);
    send_item(prrts_pkg::OP_LAUNCH, 0, 0, 0, 0);
    send_item(prrts_pkg::OP_PERIODIC, 0, 32'd0, 0, 0);
    send_item(prrts_pkg::OP_PERIODIC, 0, 32'hffffffff, 0, 0);
    for (int i = 0; i < 7; i++)
      send_item(prrts_pkg::OP_PERIODIC, 0, 32'($urandom_range(1, 4)), 0, 0);
    send_item(prrts_pkg::OP_TICK, 0, 0, 0, 8'hff);
    send_item(prrts_pkg::OP_TICK, 0, 0, 0, 8'h00);
    send_item(prrts_pkg::OP_KILL, 0, 0, 32'hdeadbeef, 0);
    send_item(prrts_pkg::OP_KILL, 0, 0, live_ids[1], 0);
    send_item(prrts_pkg::OP_SLEEP, 0, 32'hffffffff, 0, 8'h0f);
    drain_all();
    // random phase with occasional bursts
    rx_stall_off = 0;
    for (int n = 0; n < 152; n++) begin
      op = $urandom_range(0, 9);
      if (op > 7) op = prrts_pkg::OP_TICK;
      if (op == prrts_pkg::OP_KILL) begin
        t = pick_target();
        send_item(prrts_pkg::OP_KILL, 0, 0, t, 8'($urandom), n % 20 < 3);
      end else begin
        send_item(3'(op), 8'($urandom),
                  (op == prrts_pkg::OP_PERIODIC || $urandom_range(0, 1)) ?
                  32'($urandom_range(0, 6)) : 32'($urandom), $urandom, 8'($urandom),
                  n % 20 < 3);
      end
      if (n == 90) begin
        drain_all();
        rx_stall_off = 1;
      end
      if (n == 130) rx_stall_off = 0;
    end
    drain_all();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
